// ===== hdl/tlsd_pkg.sv =====
// Package for the timed lighting schedule duty block.
// Holds field widths, codes, the stored entry layout and the duty table builder.
// No dependencies.
`default_nettype none

package tlsd_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int FULL_DUTY_DEF   = 8191;

    localparam int FUNC_W    = 1;
    localparam int INDEX_W   = 4;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int IN_LVL_W  = 8;
    localparam int LVL_W     = 7;
    localparam int NUM_LVL   = 7;
    localparam int DUTY_W    = 12;
    localparam int STATUS_W  = 2;
    localparam int TIME_W    = HOUR_W + MINUTE_W;

    localparam int MODE_W    = 2;
    localparam int STATIC_W  = 7;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 7;

    localparam int LEVEL_MAX   = 100;
    localparam int LEVEL_CODES = 1 << LVL_W;
    localparam longint unsigned PCT_SCALE = 10000;
    localparam int K_STD  = 35;
    localparam int K_BLUE = 40;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_EVAL  = 1'b1;

    localparam logic [MODE_W-1:0] MODE_MANUAL   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SCHEDULE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NONE     = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_ACT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATIC_RED     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STATIC_GREEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STATIC_BLUE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 3'd4;

    // level order: red, green, blue, white, warm white, royal blue, ultra violet
    localparam int LV_RED    = 0;
    localparam int LV_GREEN  = 1;
    localparam int LV_BLUE   = 2;
    localparam int LV_WHITE  = 3;
    localparam int LV_WARM   = 4;
    localparam int LV_ROYAL  = 5;
    localparam int LV_UV     = 6;

    typedef logic [NUM_LVL-1:0][LVL_W-1:0] levels_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        levels_t             lvl;
    } entry_t;

    typedef logic [LEVEL_CODES-1:0][DUTY_W-1:0] duty_tab_t;

    function automatic logic [LVL_W-1:0] sat100(input logic [IN_LVL_W-1:0] v);
        logic [LVL_W-1:0] r;
        if (v > IN_LVL_W'(LEVEL_MAX))
            r = LVL_W'(LEVEL_MAX);
        else
            r = v[LVL_W-1:0];
        return r;
    endfunction

    function automatic duty_tab_t make_duty_tab(input longint unsigned k,
                                                input longint unsigned full);
        duty_tab_t        tab;
        longint unsigned  lvl;
        for (int i = 0; i < LEVEL_CODES; i++)
        begin
            lvl    = (i > LEVEL_MAX) ? longint'(LEVEL_MAX) : longint'(i);
            tab[i] = DUTY_W'((lvl * full * k) / PCT_SCALE);
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tlsd_ifaces.sv =====
// Valid/ready channel interfaces for the timed lighting schedule duty block.
// Item channel carries write and evaluate beats; result channel carries duties.
// Depends on tlsd_pkg.
`default_nettype none

interface tlsd_item_if;
    logic                              valid;
    logic                              ready;
    logic [tlsd_pkg::FUNC_W-1:0]       func;
    logic [tlsd_pkg::INDEX_W-1:0]      entry_index;
    logic [tlsd_pkg::HOUR_W-1:0]       hour;
    logic [tlsd_pkg::MINUTE_W-1:0]     minute;
    logic [tlsd_pkg::IN_LVL_W-1:0]     level_red;
    logic [tlsd_pkg::IN_LVL_W-1:0]     level_green;
    logic [tlsd_pkg::IN_LVL_W-1:0]     level_blue;
    logic [tlsd_pkg::IN_LVL_W-1:0]     level_white;
    logic [tlsd_pkg::IN_LVL_W-1:0]     level_warm_white;
    logic [tlsd_pkg::IN_LVL_W-1:0]     level_royal_blue;
    logic [tlsd_pkg::IN_LVL_W-1:0]     level_ultra_violet;

    modport source (
        output valid, func, entry_index, hour, minute, level_red, level_green,
               level_blue, level_white, level_warm_white, level_royal_blue,
               level_ultra_violet,
        input  ready
    );

    modport sink (
        input  valid, func, entry_index, hour, minute, level_red, level_green,
               level_blue, level_white, level_warm_white, level_royal_blue,
               level_ultra_violet,
        output ready
    );
endinterface

interface tlsd_result_if;
    logic                              valid;
    logic                              ready;
    logic [tlsd_pkg::STATUS_W-1:0]     status;
    logic [tlsd_pkg::DUTY_W-1:0]       duty_red;
    logic [tlsd_pkg::DUTY_W-1:0]       duty_green;
    logic [tlsd_pkg::DUTY_W-1:0]       duty_blue;
    logic [tlsd_pkg::DUTY_W-1:0]       duty_white;
    logic [tlsd_pkg::DUTY_W-1:0]       duty_warm_white;
    logic [tlsd_pkg::DUTY_W-1:0]       duty_royal_blue;
    logic [tlsd_pkg::DUTY_W-1:0]       duty_ultra_violet;
    logic [tlsd_pkg::DUTY_W-1:0]       duty_violet;
    logic [tlsd_pkg::HOUR_W-1:0]       chosen_hour;
    logic [tlsd_pkg::MINUTE_W-1:0]     chosen_minute;

    modport source (
        output valid, status, duty_red, duty_green, duty_blue, duty_white,
               duty_warm_white, duty_royal_blue, duty_ultra_violet, duty_violet,
               chosen_hour, chosen_minute,
        input  ready
    );

    modport sink (
        input  valid, status, duty_red, duty_green, duty_blue, duty_white,
               duty_warm_white, duty_royal_blue, duty_ultra_violet, duty_violet,
               chosen_hour, chosen_minute,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/timed_light_schedule_duty_top.sv =====
// Top level of the timed lighting schedule duty block.
// Schedule table memory, scan sequencer, duty lookup and result register.
// Depends on tlsd_pkg and tlsd_ifaces.
//
// A write beat stores one schedule entry in a synchronous table with one write
// and one read port; it gives no result. An evaluate beat in manual or
// no-action mode goes from the idle state straight to the finishing step that
// loads the result register. In schedule mode, when entries_in_use clamped to
// MAX_ENTRIES is not zero, the scan reads one table entry per cycle through the
// single read port, the read data is registered, and a drain step comes before
// the finishing step. One evaluate is in flight at a time; a finished result waits in
// its own register, so the next beat is taken while it is unread. The table has
// no reset and needs no clearing pass: every entry taking part in a scan must
// have been written first.
`default_nettype none

module timed_light_schedule_duty_top #(
    parameter int MAX_ENTRIES = tlsd_pkg::MAX_ENTRIES_DEF,
    parameter int FULL_DUTY   = tlsd_pkg::FULL_DUTY_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [tlsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tlsd_pkg::CFG_DATA_W-1:0]   cfg_data,
    tlsd_item_if.sink                              item,
    tlsd_result_if.source                          result
);

    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

    localparam tlsd_pkg::duty_tab_t DUTY_STD =
        tlsd_pkg::make_duty_tab(longint'(tlsd_pkg::K_STD), longint'(FULL_DUTY));
    localparam tlsd_pkg::duty_tab_t DUTY_BLUE =
        tlsd_pkg::make_duty_tab(longint'(tlsd_pkg::K_BLUE), longint'(FULL_DUTY));

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [1:0] KIND_MANUAL = 2'd0;
    localparam logic [1:0] KIND_SCHED  = 2'd1;
    localparam logic [1:0] KIND_NO_ACT = 2'd2;

    tlsd_pkg::entry_t mem [MAX_ENTRIES];
    tlsd_pkg::entry_t rd_data_reg;
    tlsd_pkg::entry_t wr_data;
    logic             wr_en;
    logic [ADDR_W-1:0] wr_addr;

    logic [1:0] state_reg, state_next;
    logic [1:0] kind_reg, kind_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic rd_vld_reg, rd_vld_next;
    logic found_reg, found_next;
    logic [tlsd_pkg::TIME_W-1:0] now_reg, now_next;
    logic [tlsd_pkg::TIME_W-1:0] best_t_reg, best_t_next;
    tlsd_pkg::levels_t lvl_reg, lvl_next;

    logic [tlsd_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic [tlsd_pkg::STATIC_W-1:0] red_reg, red_next;
    logic [tlsd_pkg::STATIC_W-1:0] green_reg, green_next;
    logic [tlsd_pkg::STATIC_W-1:0] blue_reg, blue_next;
    logic [tlsd_pkg::COUNT_W-1:0]  use_reg, use_next;

    logic res_valid_reg, res_valid_next;
    logic [tlsd_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [7:0][tlsd_pkg::DUTY_W-1:0] duty_reg, duty_next;
    logic [tlsd_pkg::HOUR_W-1:0]   ch_hour_reg, ch_hour_next;
    logic [tlsd_pkg::MINUTE_W-1:0] ch_min_reg, ch_min_next;

    logic item_acc;
    logic load_res;
    logic live;
    logic [tlsd_pkg::TIME_W-1:0] rd_t;
    logic [CNT_W-1:0] n_clamped;

    assign item.ready = (state_reg == ST_IDLE);
    assign item_acc   = item.valid && item.ready;

    assign n_clamped = (32'(use_reg) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                    : CNT_W'(use_reg);

    assign rd_t = {rd_data_reg.hour, rd_data_reg.minute};

    always_comb
    begin
        wr_en   = item_acc && (item.func == tlsd_pkg::FUNC_WRITE)
                  && (32'(item.entry_index) < MAX_ENTRIES);
        wr_addr = ADDR_W'(item.entry_index);
        wr_data.hour   = item.hour;
        wr_data.minute = item.minute;
        wr_data.lvl[tlsd_pkg::LV_RED]   = tlsd_pkg::sat100(item.level_red);
        wr_data.lvl[tlsd_pkg::LV_GREEN] = tlsd_pkg::sat100(item.level_green);
        wr_data.lvl[tlsd_pkg::LV_BLUE]  = tlsd_pkg::sat100(item.level_blue);
        wr_data.lvl[tlsd_pkg::LV_WHITE] = tlsd_pkg::sat100(item.level_white);
        wr_data.lvl[tlsd_pkg::LV_WARM]  = tlsd_pkg::sat100(item.level_warm_white);
        wr_data.lvl[tlsd_pkg::LV_ROYAL] = tlsd_pkg::sat100(item.level_royal_blue);
        wr_data.lvl[tlsd_pkg::LV_UV]    = tlsd_pkg::sat100(item.level_ultra_violet);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[cnt_reg[ADDR_W-1:0]];
    end

    // configuration
    always_comb
    begin
        mode_next  = mode_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        use_next   = use_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tlsd_pkg::CFG_LIGHT_MODE:     mode_next  = cfg_data[tlsd_pkg::MODE_W-1:0];
                tlsd_pkg::CFG_STATIC_RED:     red_next   = cfg_data[tlsd_pkg::STATIC_W-1:0];
                tlsd_pkg::CFG_STATIC_GREEN:   green_next = cfg_data[tlsd_pkg::STATIC_W-1:0];
                tlsd_pkg::CFG_STATIC_BLUE:    blue_next  = cfg_data[tlsd_pkg::STATIC_W-1:0];
                tlsd_pkg::CFG_ENTRIES_IN_USE: use_next   = cfg_data[tlsd_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and scan
    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        cnt_next    = cnt_reg;
        n_next      = n_reg;
        found_next  = found_reg;
        now_next    = now_reg;
        best_t_next = best_t_reg;
        lvl_next    = lvl_reg;
        rd_vld_next = (state_reg == ST_SCAN);
        load_res    = 1'b0;

        if (rd_vld_reg && (rd_t <= now_reg) && (!found_reg || (rd_t > best_t_reg)))
        begin
            found_next  = 1'b1;
            best_t_next = rd_t;
            lvl_next    = rd_data_reg.lvl;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc && (item.func == tlsd_pkg::FUNC_EVAL))
                begin
                    now_next   = {item.hour, item.minute};
                    found_next = 1'b0;
                    cnt_next   = '0;
                    n_next     = n_clamped;
                    state_next = ST_FINISH;
                    case (mode_reg)
                        tlsd_pkg::MODE_MANUAL:
                        begin
                            kind_next = KIND_MANUAL;
                            lvl_next  = '0;
                            lvl_next[tlsd_pkg::LV_RED]   = tlsd_pkg::sat100(8'(red_reg));
                            lvl_next[tlsd_pkg::LV_GREEN] = tlsd_pkg::sat100(8'(green_reg));
                            lvl_next[tlsd_pkg::LV_BLUE]  = tlsd_pkg::sat100(8'(blue_reg));
                        end
                        tlsd_pkg::MODE_SCHEDULE:
                        begin
                            kind_next = KIND_SCHED;
                            if (n_clamped != '0)
                                state_next = ST_SCAN;
                        end
                        default:
                            kind_next = KIND_NO_ACT;
                    endcase
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_next == n_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    load_res   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // result register
    always_comb
    begin
        live = (kind_reg == KIND_MANUAL) || ((kind_reg == KIND_SCHED) && found_reg);

        res_valid_next = res_valid_reg && !result.ready;
        status_next    = status_reg;
        duty_next      = duty_reg;
        ch_hour_next   = ch_hour_reg;
        ch_min_next    = ch_min_reg;

        if (load_res)
        begin
            res_valid_next = 1'b1;
            if (kind_reg == KIND_NO_ACT)
                status_next = tlsd_pkg::STATUS_NO_ACT;
            else if (live)
                status_next = tlsd_pkg::STATUS_OK;
            else
                status_next = tlsd_pkg::STATUS_NONE;

            duty_next = '0;
            if (live)
            begin
                duty_next[0] = DUTY_STD[lvl_reg[tlsd_pkg::LV_RED]];
                duty_next[1] = DUTY_STD[lvl_reg[tlsd_pkg::LV_GREEN]];
                duty_next[2] = DUTY_BLUE[lvl_reg[tlsd_pkg::LV_BLUE]];
                duty_next[3] = DUTY_STD[lvl_reg[tlsd_pkg::LV_WHITE]];
                duty_next[4] = DUTY_STD[lvl_reg[tlsd_pkg::LV_WARM]];
                duty_next[5] = DUTY_BLUE[lvl_reg[tlsd_pkg::LV_ROYAL]];
                duty_next[6] = DUTY_STD[lvl_reg[tlsd_pkg::LV_UV]];
                duty_next[7] = DUTY_STD[lvl_reg[tlsd_pkg::LV_UV]];
            end

            if ((kind_reg == KIND_SCHED) && found_reg)
            begin
                ch_hour_next = best_t_reg[tlsd_pkg::TIME_W-1:tlsd_pkg::MINUTE_W];
                ch_min_next  = best_t_reg[tlsd_pkg::MINUTE_W-1:0];
            end
            else
            begin
                ch_hour_next = '0;
                ch_min_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_NO_ACT;
            cnt_reg       <= '0;
            n_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            mode_reg      <= tlsd_pkg::MODE_NONE;
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
            use_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
            mode_reg      <= mode_next;
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
            use_reg       <= use_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        best_t_reg  <= best_t_next;
        lvl_reg     <= lvl_next;
        status_reg  <= status_next;
        duty_reg    <= duty_next;
        ch_hour_reg <= ch_hour_next;
        ch_min_reg  <= ch_min_next;
    end

    assign result.valid             = res_valid_reg;
    assign result.status            = status_reg;
    assign result.duty_red          = duty_reg[0];
    assign result.duty_green        = duty_reg[1];
    assign result.duty_blue         = duty_reg[2];
    assign result.duty_white        = duty_reg[3];
    assign result.duty_warm_white   = duty_reg[4];
    assign result.duty_royal_blue   = duty_reg[5];
    assign result.duty_ultra_violet = duty_reg[6];
    assign result.duty_violet       = duty_reg[7];
    assign result.chosen_hour       = ch_hour_reg;
    assign result.chosen_minute     = ch_min_reg;

    a_new_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared without a finishing step");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg < n_reg))
        else $error("scan address past entries in use");

    a_best_not_after_now: assert property (@(posedge clk) disable iff (!rst_n)
        (found_reg && (state_reg != ST_IDLE)) |-> (best_t_reg <= now_reg))
        else $error("chosen entry later than current time");

    a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (status_reg != tlsd_pkg::STATUS_OK))
        |-> ((duty_reg == '0) && (ch_hour_reg == '0) && (ch_min_reg == '0)))
        else $error("non-applied result carries duties");

endmodule

`default_nettype wire
